// ----- rtl/assert_macros.svh -----
// Assertion helpers for the replacement core.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked only while reset is released.
`define SLRU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define SLRU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SLRU_ASSERT(label, prop, msg)
`define SLRU_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ----- rtl/slru_pkg.sv -----
`timescale 1ns / 1ps

package slru_pkg;

    localparam int KEY_W     = 64;
    localparam int SLOT_W    = 4;
    localparam int OUTCOME_W = 3;
    localparam int PMAX_W    = 5;

    // Result outcome codes
    localparam logic [OUTCOME_W-1:0] OUT_PROT_HIT   = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_PROB_HIT   = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_FREE_FILL  = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_PROB_EVICT = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_PROT_EVICT = 3'd4;

    // Kind of rank update applied during the write-back sweep
    typedef enum logic [1:0] {
        OP_PROT_HIT,
        OP_PROB_HIT,
        OP_FILL,
        OP_EVICT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic demote;
    } unit_ctl_t;

    // Per-entry flags from the lookup sweep
    typedef struct packed {
        logic hit;
        logic prob_lru;
        logic prot_lru;
    } srch_flags_t;

endpackage

// ----- rtl/slru_mem.sv -----
`timescale 1ns / 1ps

module slru_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 69
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/slru_lane_unit.sv -----
`timescale 1ns / 1ps

module slru_lane_unit #(
    parameter int IDX_W = 4,
    parameter int CNT_W = 5
) (
    input  logic [slru_pkg::KEY_W-1:0] key_in,
    input  logic [slru_pkg::KEY_W-1:0] ent_key,
    input  logic                       ent_prot,
    input  logic [IDX_W-1:0]           ent_rank,
    input  logic [IDX_W-1:0]           ent_idx,
    input  logic [CNT_W-1:0]           prot_cnt,
    input  logic [CNT_W-1:0]           prob_cnt,
    input  slru_pkg::unit_ctl_t        ctl,
    input  logic [IDX_W-1:0]           tgt_slot,
    input  logic [IDX_W-1:0]           tgt_rank,
    input  logic [IDX_W-1:0]           vic_slot,
    output slru_pkg::srch_flags_t      flags,
    output logic [slru_pkg::KEY_W-1:0] new_key,
    output logic                       new_prot,
    output logic [IDX_W-1:0]           new_rank
);

    import slru_pkg::*;

    logic [CNT_W-1:0] rank_p1;
    logic             is_tgt;
    logic             is_vic;

    assign rank_p1 = CNT_W'(ent_rank) + CNT_W'(1);
    assign is_tgt  = (ent_idx == tgt_slot);
    assign is_vic  = (ent_idx == vic_slot);

    // Lookup: key match and LRU position of each segment
    assign flags.hit      = (ent_key == key_in);
    assign flags.prob_lru = !ent_prot && (rank_p1 == prob_cnt);
    assign flags.prot_lru = ent_prot && (rank_p1 == prot_cnt);

    // Write-back: new segment and rank for one entry
    always_comb
    begin
        new_key  = ent_key;
        new_prot = ent_prot;
        new_rank = ent_rank;
        case (ctl.op)
            OP_PROT_HIT:
            begin
                if (is_tgt)
                begin
                    new_prot = 1'b1;
                    new_rank = '0;
                end
                else if (ent_prot && (ent_rank < tgt_rank))
                begin
                    new_rank = ent_rank + IDX_W'(1);
                end
            end
            OP_PROB_HIT:
            begin
                if (is_tgt)
                begin
                    // promoted entry, demoted straight back when limit is zero
                    new_prot = !(ctl.demote && is_vic);
                    new_rank = '0;
                end
                else if (ctl.demote && is_vic)
                begin
                    new_prot = 1'b0;
                    new_rank = '0;
                end
                else if (ent_prot)
                begin
                    new_rank = ent_rank + IDX_W'(1);
                end
                else
                begin
                    new_rank = ent_rank - IDX_W'(ent_rank > tgt_rank) + IDX_W'(ctl.demote);
                end
            end
            OP_FILL, OP_EVICT:
            begin
                if (is_tgt)
                begin
                    new_key  = key_in;
                    new_prot = 1'b0;
                    new_rank = '0;
                end
                else if (!ent_prot)
                begin
                    new_rank = ent_rank + IDX_W'(1);
                end
            end
            default:
            begin
                new_rank = ent_rank;
            end
        endcase
    end

endmodule

// ----- rtl/segmented_lru_replacement_core.sv -----
// A request taken in idle runs a lookup sweep, a decide step and a write-back sweep, then ends with done;
// a free fill adds the newly filled slot to the write-back sweep. One request at a time: each slot in use
// is read from the entry RAM twice (lookup sweep, then write-back sweep); busy is high until the done
// cycle, and start is taken in the done cycle.
// Results are a one-cycle done strobe; the receiver cannot stall.
// Reset (rst_n low, asynchronous): segments empty, protected_max = ENTRIES/2; no RAM clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module segmented_lru_replacement_core #(
    parameter int ENTRIES = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [slru_pkg::KEY_W-1:0]     key,
    input  logic                           protected_max_we,
    input  logic [slru_pkg::PMAX_W-1:0]    protected_max,
    output logic                           done,
    output logic [slru_pkg::SLOT_W-1:0]    slot,
    output logic [slru_pkg::OUTCOME_W-1:0] outcome,
    output logic [slru_pkg::KEY_W-1:0]     evicted_key,
    output logic                           demoted
);

    import slru_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int PM_W  = (CNT_W > PMAX_W) ? CNT_W : PMAX_W;
    localparam int CMP_W = PM_W + 1;
    localparam int MW    = KEY_W + 1 + IDX_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_UPDATE
    } state_t;

    state_t                 state_reg, state_next;
    logic [PM_W-1:0]        pmax_reg, pmax_next;
    logic [CNT_W-1:0]       used_reg, used_next;
    logic [CNT_W-1:0]       prot_cnt_reg, prot_cnt_next;
    logic [CNT_W-1:0]       prob_cnt_reg, prob_cnt_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       limit_reg, limit_next;
    logic                   rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                   hit_found_reg, hit_found_next;
    logic                   hit_prot_reg, hit_prot_next;
    logic [IDX_W-1:0]       hit_slot_reg, hit_slot_next;
    logic [IDX_W-1:0]       hit_rank_reg, hit_rank_next;
    logic [IDX_W-1:0]       prob_lru_reg, prob_lru_next;
    logic [IDX_W-1:0]       prot_lru_reg, prot_lru_next;
    unit_ctl_t              ctl_reg, ctl_next;
    logic [IDX_W-1:0]       s_reg, s_next;
    logic [IDX_W-1:0]       v_reg, v_next;
    logic                   done_reg, done_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [OUTCOME_W-1:0]   outcome_reg, outcome_next;
    logic [KEY_W-1:0]       evk_reg, evk_next;
    logic                   demoted_reg, demoted_next;

    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic [MW-1:0]          rd_data;
    logic                   wr_en;
    logic [MW-1:0]          wr_data;
    logic [KEY_W-1:0]       ent_key;
    logic                   ent_prot;
    logic [IDX_W-1:0]       ent_rank;
    srch_flags_t            flags;
    logic [KEY_W-1:0]       new_key;
    logic                   new_prot;
    logic [IDX_W-1:0]       new_rank;

    // Entry RAM: {key, protected flag, recency rank}
    slru_mem #(
        .DEPTH (ENTRIES),
        .AW    (IDX_W),
        .DW    (MW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (rd_idx_reg),
        .wr_data (wr_data)
    );

    assign ent_key  = rd_data[MW-1 -: KEY_W];
    assign ent_prot = rd_data[IDX_W];
    assign ent_rank = rd_data[IDX_W-1:0];
    assign wr_data  = {new_key, new_prot, new_rank};
    assign rd_addr  = cnt_reg[IDX_W-1:0];
    assign rd_en    = rd_valid_next;
    assign wr_en    = (state_reg == ST_UPDATE) && rd_valid_reg;

    // Shared compare / rank unit, one entry per cycle
    slru_lane_unit #(
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_lane (
        .key_in   (key_reg),
        .ent_key  (ent_key),
        .ent_prot (ent_prot),
        .ent_rank (ent_rank),
        .ent_idx  (rd_idx_reg),
        .prot_cnt (prot_cnt_reg),
        .prob_cnt (prob_cnt_reg),
        .ctl      (ctl_reg),
        .tgt_slot (s_reg),
        .tgt_rank (hit_rank_reg),
        .vic_slot (v_reg),
        .flags    (flags),
        .new_key  (new_key),
        .new_prot (new_prot),
        .new_rank (new_rank)
    );

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign slot        = slot_reg;
    assign outcome     = outcome_reg;
    assign evicted_key = evk_reg;
    assign demoted     = demoted_reg;

    // Sequencer next-state logic
    always_comb
    begin
        state_next     = state_reg;
        pmax_next      = pmax_reg;
        used_next      = used_reg;
        prot_cnt_next  = prot_cnt_reg;
        prob_cnt_next  = prob_cnt_reg;
        key_next       = key_reg;
        cnt_next       = cnt_reg;
        limit_next     = limit_reg;
        rd_valid_next  = 1'b0;
        rd_idx_next    = cnt_reg[IDX_W-1:0];
        hit_found_next = hit_found_reg;
        hit_prot_next  = hit_prot_reg;
        hit_slot_next  = hit_slot_reg;
        hit_rank_next  = hit_rank_reg;
        prob_lru_next  = prob_lru_reg;
        prot_lru_next  = prot_lru_reg;
        ctl_next       = ctl_reg;
        s_next         = s_reg;
        v_next         = v_reg;
        done_next      = 1'b0;
        slot_next      = slot_reg;
        outcome_next   = outcome_reg;
        evk_next       = evk_reg;
        demoted_next   = demoted_reg;

        if (protected_max_we)
        begin
            pmax_next = PM_W'(protected_max);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    key_next       = key;
                    cnt_next       = '0;
                    limit_next     = used_reg;
                    hit_found_next = 1'b0;
                    prob_lru_next  = '0;
                    prot_lru_next  = '0;
                    state_next     = ST_SEARCH;
                end
            end

            // Lookup sweep: key match and both LRU slots
            ST_SEARCH:
            begin
                if (rd_valid_reg)
                begin
                    if (flags.hit)
                    begin
                        hit_found_next = 1'b1;
                        hit_prot_next  = ent_prot;
                        hit_slot_next  = rd_idx_reg;
                        hit_rank_next  = ent_rank;
                    end
                    if (flags.prob_lru)
                    begin
                        prob_lru_next = rd_idx_reg;
                    end
                    if (flags.prot_lru)
                    begin
                        prot_lru_next = rd_idx_reg;
                    end
                end
                if (cnt_reg != limit_reg)
                begin
                    rd_valid_next = 1'b1;
                    cnt_next      = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
            end

            // Pick the case, target and victim; settle the counts
            ST_DECIDE:
            begin
                ctl_next.demote = 1'b0;
                demoted_next    = 1'b0;
                evk_next        = '0;
                if (hit_found_reg && hit_prot_reg)
                begin
                    ctl_next.op  = OP_PROT_HIT;
                    s_next       = hit_slot_reg;
                    v_next       = hit_slot_reg;
                    outcome_next = OUT_PROT_HIT;
                end
                else if (hit_found_reg)
                begin
                    ctl_next.op  = OP_PROB_HIT;
                    s_next       = hit_slot_reg;
                    outcome_next = OUT_PROB_HIT;
                    v_next       = (prot_cnt_reg == '0) ? hit_slot_reg : prot_lru_reg;
                    if ((CMP_W'(prot_cnt_reg) + CMP_W'(1)) > CMP_W'(pmax_reg))
                    begin
                        ctl_next.demote = 1'b1;
                        demoted_next    = 1'b1;
                    end
                    else
                    begin
                        prot_cnt_next = prot_cnt_reg + CNT_W'(1);
                        prob_cnt_next = prob_cnt_reg - CNT_W'(1);
                    end
                end
                else if (used_reg < CNT_W'(ENTRIES))
                begin
                    ctl_next.op   = OP_FILL;
                    s_next        = used_reg[IDX_W-1:0];
                    v_next        = used_reg[IDX_W-1:0];
                    outcome_next  = OUT_FREE_FILL;
                    used_next     = used_reg + CNT_W'(1);
                    prob_cnt_next = prob_cnt_reg + CNT_W'(1);
                end
                else if (prob_cnt_reg != '0)
                begin
                    ctl_next.op  = OP_EVICT;
                    s_next       = prob_lru_reg;
                    v_next       = prob_lru_reg;
                    outcome_next = OUT_PROB_EVICT;
                end
                else
                begin
                    ctl_next.op   = OP_EVICT;
                    s_next        = prot_lru_reg;
                    v_next        = prot_lru_reg;
                    outcome_next  = OUT_PROT_EVICT;
                    prot_cnt_next = prot_cnt_reg - CNT_W'(1);
                    prob_cnt_next = prob_cnt_reg + CNT_W'(1);
                end
                slot_next  = SLOT_W'(s_next);
                cnt_next   = '0;
                limit_next = used_next;
                state_next = ST_UPDATE;
            end

            // Write-back sweep over every used slot
            ST_UPDATE:
            begin
                if (rd_valid_reg && (rd_idx_reg == s_reg) && (ctl_reg.op == OP_EVICT))
                begin
                    evk_next = ent_key;
                end
                if (cnt_reg != limit_reg)
                begin
                    rd_valid_next = 1'b1;
                    cnt_next      = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pmax_reg      <= PM_W'(ENTRIES / 2);
            used_reg      <= '0;
            prot_cnt_reg  <= '0;
            prob_cnt_reg  <= '0;
            key_reg       <= '0;
            cnt_reg       <= '0;
            limit_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            rd_idx_reg    <= '0;
            hit_found_reg <= 1'b0;
            hit_prot_reg  <= 1'b0;
            hit_slot_reg  <= '0;
            hit_rank_reg  <= '0;
            prob_lru_reg  <= '0;
            prot_lru_reg  <= '0;
            ctl_reg       <= '{op: OP_PROT_HIT, demote: 1'b0};
            s_reg         <= '0;
            v_reg         <= '0;
            done_reg      <= 1'b0;
            slot_reg      <= '0;
            outcome_reg   <= OUT_PROT_HIT;
            evk_reg       <= '0;
            demoted_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pmax_reg      <= pmax_next;
            used_reg      <= used_next;
            prot_cnt_reg  <= prot_cnt_next;
            prob_cnt_reg  <= prob_cnt_next;
            key_reg       <= key_next;
            cnt_reg       <= cnt_next;
            limit_reg     <= limit_next;
            rd_valid_reg  <= rd_valid_next;
            rd_idx_reg    <= rd_idx_next;
            hit_found_reg <= hit_found_next;
            hit_prot_reg  <= hit_prot_next;
            hit_slot_reg  <= hit_slot_next;
            hit_rank_reg  <= hit_rank_next;
            prob_lru_reg  <= prob_lru_next;
            prot_lru_reg  <= prot_lru_next;
            ctl_reg       <= ctl_next;
            s_reg         <= s_next;
            v_reg         <= v_next;
            done_reg      <= done_next;
            slot_reg      <= slot_next;
            outcome_reg   <= outcome_next;
            evk_reg       <= evk_next;
            demoted_reg   <= demoted_next;
        end
    end

    // Checks
    `SLRU_ASSERT(a_seg_sum, (CMP_W'(prot_cnt_reg) + CMP_W'(prob_cnt_reg)) == CMP_W'(used_reg), "segment counts do not add up to used slots")
    `SLRU_ASSERT(a_used_max, used_reg <= CNT_W'(ENTRIES), "used slot count beyond capacity")
    `SLRU_ASSERT(a_done_src, done_reg |-> $past(state_reg == ST_UPDATE), "done strobe without a write-back sweep")
    `SLRU_ASSERT(a_demote_hit, (done_reg && demoted_reg) |-> (outcome_reg == OUT_PROB_HIT), "demotion reported outside a probation hit")
    `SLRU_ASSERT_ALWAYS(a_rw_clash, (rd_en && wr_en) |-> (rd_addr != rd_idx_reg), "entry RAM read and write at one address")

endmodule
